/* sv/dwd_pkg.sv */
package dwd_pkg;

    // Default number of entries the queue can hold.
    localparam int DEPTH_DEF = 16;

    // Widths of one stored word, the reported entry count, a command code and a status code.
    localparam int DATA_W  = 32;
    localparam int ECNT_W  = 5;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    // Command codes carried by an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_ERASE      = 3'd4
    } t_cmd;

    // Status codes carried by a result word.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOMATCH = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SCAN
    } t_state;

endpackage

/* sv/dwd_ram.sv */
module dwd_ram #(
    parameter int DEPTH = dwd_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [AW-1:0]                    i_waddr,
    input  logic signed [dwd_pkg::DATA_W-1:0] i_wdata,
    input  logic                             i_re,
    input  logic [AW-1:0]                    i_raddr,
    output logic signed [dwd_pkg::DATA_W-1:0] o_rdata
);
    import dwd_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/deque_with_delete_first_match.sv */
// Channel   Direction  Ports                                     Handshake
// command   in         i_cmd, i_value                            start high, busy low
// result    out        o_popped_value, o_status, o_entry_count   o_strobe, one cycle
//
// Pushes, refused pushes, failed pops, erases on an empty queue and ignored codes
// finish in the accept cycle; the result shows on the next cycle and busy stays low.
// A pop passes through S_POP_WAIT because of the registered read port of the entry memory.
// An erase passes through S_SCAN: the memory read port walks the queue from the
// front one entry a cycle and, after the match, writes each later word one slot down.
// Reset (synchronous, active low) empties the queue; the memory itself is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module deque_with_delete_first_match #(
    parameter int DEPTH = dwd_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dwd_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [dwd_pkg::DATA_W-1:0] i_value,
    output logic                              o_strobe,
    output logic signed [dwd_pkg::DATA_W-1:0] o_popped_value,
    output logic [dwd_pkg::STAT_W-1:0]        o_status,
    output logic [dwd_pkg::ECNT_W-1:0]        o_entry_count
);
    import dwd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW:0]   WRAP      = (CW + 1)'(DEPTH);

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_pidx, n_pidx;
    logic                     r_pend, n_pend;
    logic                     r_found, n_found;
    t_cmd                     r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_value, n_value;

    logic                     r_strobe, n_strobe;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    t_status                  r_status, n_status;
    logic [CW-1:0]            r_ecount, n_ecount;

    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic signed [DATA_W-1:0] ram_wdata, ram_rdata;
    logic                     match;

    // Physical slot of the entry at a given distance from the front.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] offs);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(offs);
        if (sum >= WRAP) begin
            sum = sum - WRAP;
        end
        return sum[AW-1:0];
    endfunction

    dwd_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign match = (ram_rdata == r_value);

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_pidx   <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pidx   <= n_pidx;
            r_pend   <= n_pend;
            r_found  <= n_found;
            r_strobe <= n_strobe;
        end
    end

    // Latched command word and result payload.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_popped <= n_popped;
        r_status <= n_status;
        r_ecount <= n_ecount;
    end

    // Sequencer: next state, memory controls and result.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_found   = r_found;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_strobe  = 1'b0;
        n_popped  = r_popped;
        n_status  = r_status;
        n_ecount  = r_ecount;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = i_value;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_value  = i_value;
                    n_popped = '0;
                    n_status = STAT_OK;
                    n_strobe = 1'b1;
                    case (t_cmd'(i_cmd))
                        CMD_PUSH_BACK: begin
                            if (r_count == FULL_CNT) begin
                                n_status = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = slot(r_head, r_count);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (r_count == FULL_CNT) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_head    = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = n_head;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_POP_BACK, CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = (t_cmd'(i_cmd) == CMD_POP_BACK) ?
                                            slot(r_head, r_count - 1'b1) : r_head;
                                n_strobe  = 1'b0;
                                n_state   = S_POP_WAIT;
                            end
                        end
                        CMD_ERASE: begin
                            if (r_count == '0) begin
                                n_status = STAT_NOMATCH;
                            end else begin
                                n_strobe = 1'b0;
                                n_idx    = '0;
                                n_pend   = 1'b0;
                                n_found  = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            // Unused codes leave the queue as it is.
                        end
                    endcase
                    n_ecount = n_count;
                end
            end

            S_POP_WAIT: begin
                n_popped = ram_rdata;
                n_status = STAT_OK;
                n_count  = r_count - 1'b1;
                if (r_cmd == CMD_POP_FRONT) begin
                    n_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                end
                n_ecount = n_count;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_SCAN: begin
                // Issue the next read while entries remain.
                if (r_idx < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot(r_head, r_idx);
                    n_idx     = r_idx + 1'b1;
                    n_pidx    = r_idx;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                // Compare the returned word, or move it down one slot past the match.
                if (r_pend) begin
                    if (r_found) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot(r_head, r_pidx - 1'b1);
                        ram_wdata = ram_rdata;
                    end else if (match) begin
                        n_found = 1'b1;
                    end
                    if (r_pidx == r_count - 1'b1) begin
                        n_popped = '0;
                        if (r_found || match) begin
                            n_status = STAT_OK;
                            n_count  = r_count - 1'b1;
                        end else begin
                            n_status = STAT_NOMATCH;
                        end
                        n_ecount = n_count;
                        n_pend   = 1'b0;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_entry_count  = ECNT_W'(r_ecount);

endmodule

/* test/deque_with_delete_first_match_chk.sv */
`timescale 1ns / 100ps

// Watches the command and result channels of the deque, keeps a shadow copy
// of its contents and compares every result word with the predicted one.
module deque_with_delete_first_match_chk #(
    parameter int DEPTH = dwd_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [dwd_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [dwd_pkg::DATA_W-1:0] i_value,
    input  logic                              i_strobe,
    input  logic signed [dwd_pkg::DATA_W-1:0] i_popped_value,
    input  logic [dwd_pkg::STAT_W-1:0]        i_status,
    input  logic [dwd_pkg::ECNT_W-1:0]        i_entry_count,
    output int                                o_fail_cnt,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_full_seen,
    output int                                o_empty_seen,
    output int                                o_miss_seen
);
    import dwd_pkg::*;

    // One result word as the block reports it.
    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic [STAT_W-1:0]        status;
        logic [ECNT_W-1:0]        count;
    } t_result;

    // Shadow contents, front first, and the results still to come.
    logic signed [DATA_W-1:0] held_words[$];
    t_result                  due_results[$];
    t_result                  want;
    t_result                  seen;

    // Applies one command to the shadow contents and returns the result word.
    function automatic t_result deque_outcome(input logic [CMD_W-1:0] cmd,
                                              input logic signed [DATA_W-1:0] val);
        t_result r;
        int      hit;
        r.popped = '0;
        r.status = STAT_OK;
        hit = -1;
        case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (held_words.size() >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (cmd == CMD_PUSH_BACK) begin
                    held_words.push_back(val);
                end else begin
                    held_words.push_front(val);
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                if (held_words.size() == 0) begin
                    r.status = STAT_EMPTY;
                end else if (cmd == CMD_POP_BACK) begin
                    r.popped = held_words.pop_back();
                end else begin
                    r.popped = held_words.pop_front();
                end
            end
            CMD_ERASE: begin
                // Only the first match counted from the front goes away.
                for (int i = 0; i < held_words.size(); i++)
                    if (hit < 0 && held_words[i] == val)
                        hit = i;
                if (hit < 0) begin
                    r.status = STAT_NOMATCH;
                end else begin
                    held_words.delete(hit);
                end
            end
            default: begin
                // Unused codes leave the contents alone.
            end
        endcase
        r.count = ECNT_W'(held_words.size());
        return r;
    endfunction

    // Predict on every accepted command word and check every result word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_words.delete();
            due_results.delete();
        end else begin
            if (start && !busy) begin
                want = deque_outcome(i_cmd, i_value);
                due_results.push_back(want);
                if (want.status == STAT_FULL)
                    o_full_seen++;
                if (want.status == STAT_EMPTY)
                    o_empty_seen++;
                if (want.status == STAT_NOMATCH)
                    o_miss_seen++;
            end
            if (i_strobe) begin
                seen = '{popped: i_popped_value, status: i_status, count: i_entry_count};
                if (due_results.size() == 0) begin
                    o_fail_cnt++;
                    $display("%0t: result word with nothing outstanding: value=%0d status=%0d count=%0d",
                             $time, seen.popped, seen.status, seen.count);
                end else begin
                    want = due_results.pop_front();
                    o_checked++;
                    if (seen !== want) begin
                        o_fail_cnt++;
                        $display("%0t: result %0d expected value=%0d status=%0d count=%0d",
                                 $time, o_checked, want.popped, want.status, want.count);
                        $display("%0t: result %0d actual   value=%0d status=%0d count=%0d",
                                 $time, o_checked, seen.popped, seen.status, seen.count);
                    end
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

/* test/deque_with_delete_first_match_tb.sv */
`timescale 1ns / 100ps

// Drives directed command words and then random bursts into the deque and reports
// the verdict from the checker's failure count.
module deque_with_delete_first_match_tb;
    import dwd_pkg::*;

    localparam int DEPTH    = DEPTH_DEF;
    localparam int N_RANDOM = 1000;

    // Codes past the last defined command are accepted and ignored.
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_ERASE + 1);
    localparam logic [CMD_W-1:0] CMD_LAST_CODE    = '1;

    // How a burst leans: toward filling, toward draining, or evenly mixed.
    localparam int LEAN_FILL  = 0;
    localparam int LEAN_DRAIN = 1;
    localparam int LEAN_MIX   = 2;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         i_cmd;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_strobe;
    logic signed [DATA_W-1:0] o_popped_value;
    logic [STAT_W-1:0]        o_status;
    logic [ECNT_W-1:0]        o_entry_count;

    int fail_cnt, pending, checked, full_seen, empty_seen, miss_seen;
    int words_sent;

    // Values that repeat often, so that erases find matches.
    logic signed [DATA_W-1:0] common_vals[8] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sh7fff_ffff,
        32'sh8000_0000, 32'sd42, -32'sd42, 32'sh5555_5555
    };

    deque_with_delete_first_match #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    deque_with_delete_first_match_chk #(
        .DEPTH(DEPTH)
    ) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_strobe       (o_strobe),
        .i_popped_value (o_popped_value),
        .i_status       (o_status),
        .i_entry_count  (o_entry_count),
        .o_fail_cnt     (fail_cnt),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen),
        .o_miss_seen    (miss_seen)
    );

    // Clock generator.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Give up if the run hangs.
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic signed [DATA_W-1:0] val);
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= val;
        do
            @(posedge i_clk);
        while (busy);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Half of the values come from the common set, the rest are fully random.
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return common_vals[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // Picks a command with weights that depend on the lean of the burst.
    function automatic logic [CMD_W-1:0] pick_cmd(input int lean);
        int push_pct, pop_pct, r;
        push_pct = (lean == LEAN_FILL) ? 70 : (lean == LEAN_DRAIN) ? 15 : 40;
        pop_pct  = (lean == LEAN_DRAIN) ? 55 : (lean == LEAN_FILL) ? 15 : 35;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        if (r < 95)
            return CMD_ERASE;
        return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
    endfunction

    // Reset, directed words, then random bursts.
    initial begin
        int  burst_len, gap, lean;
        bit  drained;
        logic [CMD_W-1:0] cmd;

        drained    = 1'b0;
        words_sent = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = CMD_PUSH_BACK;
        i_value    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Pops and an erase on an empty queue, and an ignored code.
        send_word(CMD_POP_BACK, 32'sd0);
        send_word(CMD_POP_FRONT, -32'sd1);
        send_word(CMD_ERASE, 32'sd0);
        send_word(CMD_FIRST_UNUSED, 32'sd9);

        // Extremes at both ends, then a value held twice.
        send_word(CMD_PUSH_BACK, 32'sh7fff_ffff);
        send_word(CMD_PUSH_FRONT, 32'sh8000_0000);
        send_word(CMD_PUSH_BACK, -32'sd1);
        send_word(CMD_PUSH_FRONT, 32'sd0);
        send_word(CMD_PUSH_BACK, 32'sd5);
        send_word(CMD_PUSH_BACK, 32'sd7);
        send_word(CMD_PUSH_BACK, 32'sd5);

        // Erase removes only the front copy; the back one still pops.
        send_word(CMD_ERASE, 32'sd5);
        send_word(CMD_POP_BACK, 32'sd0);
        send_word(CMD_ERASE, 32'sd5);
        send_word(CMD_LAST_CODE, 32'sh7fff_ffff);
        send_word(CMD_POP_FRONT, 32'sd0);
        send_word(CMD_POP_FRONT, 32'sd0);
        send_word(CMD_POP_BACK, 32'sd0);
        send_word(CMD_ERASE, 32'sh7fff_ffff);
        send_word(CMD_ERASE, -32'sd1);
        send_word(CMD_ERASE, -32'sd1);

        // Random bursts that fill up, drain or mix, with random gaps.
        while (words_sent < N_RANDOM + 21) begin
            burst_len = $urandom_range(1, 40);
            lean      = $urandom_range(LEAN_FILL, LEAN_MIX);
            for (int k = 0; k < burst_len && words_sent < N_RANDOM + 21; k++) begin
                cmd = pick_cmd(lean);
                send_word(cmd, pick_value());
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 || (!drained && words_sent >= N_RANDOM / 2)) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
                // Once, halfway, hold off until every result is back.
                if (!drained && words_sent >= N_RANDOM / 2) begin
                    wait (pending == 0);
                    @(negedge i_clk);
                    drained = 1'b1;
                end
            end
        end
        start <= 1'b0;

        // Wait for the last results, then keep the clock running to catch stray strobes.
        wait (pending == 0);
        repeat (24) @(posedge i_clk);

        $display("Drove %0d command words and compared %0d result words.",
                 words_sent, checked);
        $display("Refused pushes %0d, pops on empty %0d, erases without match %0d.",
                 full_seen, empty_seen, miss_seen);
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
